// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/ebap_pkg.sv =====
// ---------------------------------------------------------------------------
// ebap_pkg
// Types and constants of the eased back-and-forth angle profile.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ebap_pkg;

   localparam int ANGLE_W  = 16;
   localparam int TIMER_W  = 8;
   localparam int DWELL_W  = 8;
   localparam int OFFSET_W = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;
   localparam logic [TIMER_W-1:0] TIMER_MAX    = 8'hFF;
   localparam logic [DWELL_W-1:0] DWELL_RESET  = 8'd30;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ANGLE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DWELL_FRAMES = 2'd1;

   typedef enum logic [1:0] {
      PH_FORWARD    = 2'd0,
      PH_WAIT_END   = 2'd1,
      PH_BACKWARD   = 2'd2,
      PH_WAIT_START = 2'd3
   } phase_type;

endpackage

`default_nettype wire

// ===== sv/ebap_offset_rom.sv =====
// ---------------------------------------------------------------------------
// ebap_offset_rom
// Constant swing offset table: quarter turn scaled by the running sum of the
// trapezoid weights, one entry per swing frame, built at elaboration.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ebap_offset_rom #(
   parameter int SWING_FRAMES = 90,
   parameter int PEAK_WEIGHT  = 10
) (
   input  wire logic [$clog2(SWING_FRAMES)-1:0] frame,
   output logic [ebap_pkg::OFFSET_W-1:0]        offset
);
   import ebap_pkg::*;

   localparam int IDX_W      = $clog2(SWING_FRAMES);
   localparam int DEPTH      = 2 ** IDX_W;
   localparam int THIRD      = SWING_FRAMES / 3;
   localparam int THIRD_M1   = THIRD - 1;
   localparam int TWO_THIRDS = (SWING_FRAMES * 2) / 3;
   localparam int QUARTER    = 16384;

   function automatic int cum_at(input int n);
      int acc;
      int w;
      int u;
      acc = 0;
      for (int i = 0; i < n; i++) begin
         if (i < THIRD) begin
            w = 1 + (i * (PEAK_WEIGHT - 1)) / THIRD_M1;
         end else if (i < TWO_THIRDS) begin
            w = PEAK_WEIGHT;
         end else begin
            u = i - TWO_THIRDS;
            w = PEAK_WEIGHT - (u * PEAK_WEIGHT) / THIRD_M1;
            if (w < 0) begin
               w = 0;
            end
         end
         acc = acc + w;
      end
      return acc;
   endfunction

   localparam int CUM_TOTAL = cum_at(SWING_FRAMES);

   logic [OFFSET_W-1:0] rom [0:DEPTH-1];

   for (genvar g = 0; g < DEPTH; g++) begin : g_rom
      if (g < SWING_FRAMES) begin : g_used
         localparam int CUM_G = cum_at(g + 1);
         localparam int OFF_G = (QUARTER * CUM_G) / CUM_TOTAL;
         assign rom[g] = OFFSET_W'(OFF_G);
      end else begin : g_unused
         assign rom[g] = '0;
      end
   end

   assign offset = rom[frame];

endmodule

`default_nettype wire

// ===== sv/eased_back_and_forth_angle_profile.sv =====
// ---------------------------------------------------------------------------
// eased_back_and_forth_angle_profile
// Tick-driven angle generator: eased quarter-turn swing, dwell, swing back,
// dwell, repeat.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall/req_advance) carries one tick per
//   request. advance=1 steps one frame, advance=0 only reports the outputs.
//   Every request gives exactly one response on rsp_ (angle, angle_rate,
//   phase), in order.
//   An accepted request passes from the request register into the response
//   register. Throughput: one request per cycle unless the response is
//   stalled, set by the single pass from the request register through the
//   offset table lookup and the angle adder into the response register.
//   A stalled response holds; the request register still takes a request if
//   it is empty, then req_stall stays high until the response is taken.
//   csr_write stores base_angle (index 0, also reloads the angle) or
//   dwell_frames (index 1); write only while no request is in flight.
//   Reset: forward phase, timer 0, angle 0, base_angle 0, dwell_frames 30,
//   both channels empty.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eased_back_and_forth_angle_profile #(
   parameter int SWING_FRAMES = 90,
   parameter int PEAK_WEIGHT  = 10
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_advance,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [ebap_pkg::ANGLE_W-1:0]             rsp_angle,
   output logic signed [ebap_pkg::ANGLE_W-1:0]      rsp_angle_rate,
   output ebap_pkg::phase_type                      rsp_phase,
   input  wire logic                                csr_write,
   input  wire logic [ebap_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [ebap_pkg::CSR_DATA_W-1:0]     csr_data
);
   import ebap_pkg::*;

`include "assert_macros.svh"

   localparam int IDX_W = $clog2(SWING_FRAMES);
   localparam logic [TIMER_W-1:0] SWING_END = TIMER_W'(SWING_FRAMES);

   logic                s1_valid_ff, s1_valid_in;
   logic                s1_advance_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ANGLE_W-1:0]  rsp_angle_ff;
   logic [ANGLE_W-1:0]  rsp_rate_ff;
   phase_type           rsp_phase_ff;

   logic [ANGLE_W-1:0]  base_ff, base_in;
   logic [DWELL_W-1:0]  dwell_ff, dwell_in;
   phase_type           phase_ff, phase_in;
   logic [TIMER_W-1:0]  timer_ff, timer_in;
   logic [ANGLE_W-1:0]  angle_ff, angle_in;
   logic [ANGLE_W-1:0]  rate_ff, rate_in;

   logic                move;
   logic                s1_fire;
   logic                step;
   phase_type           phase_next;
   logic [ANGLE_W-1:0]  angle_next;
   logic [ANGLE_W-1:0]  rate_next;
   logic [OFFSET_W-1:0] offset;
   logic [ANGLE_W-1:0]  offset_ext;
   logic                rsp_in_wait;

   ebap_offset_rom #(
      .SWING_FRAMES (SWING_FRAMES),
      .PEAK_WEIGHT  (PEAK_WEIGHT)
   ) u_rom (
      .frame  (timer_ff[IDX_W-1:0]),
      .offset (offset)
   );

   // handshake
   assign move      = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && move;
   assign req_stall = s1_valid_ff && !move;
   assign step      = s1_fire && s1_advance_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && !req_stall) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = move ? s1_valid_ff : rsp_valid_ff;
   end

   // profile step
   assign offset_ext = ANGLE_W'(offset);

   always_comb begin
      phase_next = phase_ff;
      angle_next = angle_ff;
      rate_next  = '0;
      case (phase_ff)
         PH_FORWARD: begin
            if (timer_ff >= SWING_END) begin
               angle_next = base_ff + QUARTER_TURN;
               phase_next = PH_WAIT_END;
            end else begin
               angle_next = base_ff + offset_ext;
               rate_next  = angle_next - angle_ff;
            end
         end
         PH_WAIT_END: begin
            if (timer_ff >= dwell_ff) begin
               phase_next = PH_BACKWARD;
            end
         end
         PH_BACKWARD: begin
            if (timer_ff >= SWING_END) begin
               angle_next = base_ff;
               phase_next = PH_WAIT_START;
            end else begin
               angle_next = base_ff + QUARTER_TURN - offset_ext;
               rate_next  = angle_next - angle_ff;
            end
         end
         PH_WAIT_START: begin
            if (timer_ff >= dwell_ff) begin
               phase_next = PH_FORWARD;
            end
         end
         default: begin
            phase_next = PH_FORWARD;
         end
      endcase
   end

   always_comb begin
      base_in  = base_ff;
      dwell_in = dwell_ff;
      phase_in = phase_ff;
      timer_in = timer_ff;
      angle_in = angle_ff;
      rate_in  = rate_ff;
      if (step) begin
         phase_in = phase_next;
         angle_in = angle_next;
         rate_in  = rate_next;
         if (phase_next != phase_ff) begin
            timer_in = '0;
         end else if (timer_ff != TIMER_MAX) begin
            timer_in = timer_ff + 1'b1;
         end
      end
      if (csr_write) begin
         case (csr_index)
            CSR_BASE_ANGLE: begin
               base_in  = csr_data[ANGLE_W-1:0];
               angle_in = csr_data[ANGLE_W-1:0];
            end
            CSR_DWELL_FRAMES: begin
               dwell_in = csr_data[DWELL_W-1:0];
            end
            default: begin
               base_in = base_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         dwell_ff     <= DWELL_RESET;
         phase_ff     <= PH_FORWARD;
         timer_ff     <= '0;
         angle_ff     <= '0;
         rate_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         dwell_ff     <= dwell_in;
         phase_ff     <= phase_in;
         timer_ff     <= timer_in;
         angle_ff     <= angle_in;
         rate_ff      <= rate_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_advance_ff <= req_advance;
      end
      if (s1_fire) begin
         rsp_angle_ff <= angle_in;
         rsp_rate_ff  <= rate_in;
         rsp_phase_ff <= phase_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_angle      = rsp_angle_ff;
   assign rsp_angle_rate = rsp_rate_ff;
   assign rsp_phase      = rsp_phase_ff;

   assign rsp_in_wait = (rsp_phase_ff == PH_WAIT_END) || (rsp_phase_ff == PH_WAIT_START);

   `ASSERT_NEXT(a_timer_clear, step && (phase_next != phase_ff), timer_ff == '0, "stale timer")
   `ASSERT_IMPL(a_wait_rate, rsp_valid_ff && rsp_in_wait, rsp_rate_ff == '0, "rate in wait")
   `ASSERT_IMPL(a_stall_empty, !s1_valid_ff, !req_stall, "stall while empty")

endmodule

`default_nettype wire
